FILE: src/tsoa_pkg.sv
// Package for the two-stacks-in-one-array block: sizes, codes and shared types.
// Used by every module of the block; depends on nothing.

package tsoa_pkg;

  // Storage geometry.
  localparam int DEPTH  = 16;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;
  localparam int IDX_W  = 4;

  // Operation codes.
  localparam logic [2:0] OP_PUSH    = 3'd0;
  localparam logic [2:0] OP_POP     = 3'd1;
  localparam logic [2:0] OP_SEARCH  = 3'd2;
  localparam logic [2:0] OP_REPLACE = 3'd3;
  localparam logic [2:0] OP_DUMP    = 3'd4;

  // Stack selectors.
  localparam logic SIDE_LOW  = 1'b0;
  localparam logic SIDE_HIGH = 1'b1;

  // Result status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OVERFLOW = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  // One result beat as it leaves the sequencer.
  typedef struct packed {
    logic [1:0]               status;
    logic [IDX_W-1:0]         index;
    logic signed [DATA_W-1:0] value;
    logic                     last;
  } res_t;

  // Storage access request: one write port and one read port.
  typedef struct packed {
    logic                     we;
    logic [AW-1:0]            waddr;
    logic signed [DATA_W-1:0] wdata;
    logic                     re;
    logic [AW-1:0]            raddr;
  } mem_req_t;

  // Array index of the n-th entry of a stack, counted from its bottom.
  function automatic logic [AW-1:0] slot_of(input logic side, input logic [CNT_W-1:0] n);
    logic [AW-1:0] top;
    top = AW'(DEPTH - 1);
    return (side == SIDE_HIGH) ? (top - n[AW-1:0]) : n[AW-1:0];
  endfunction

  // Array index as reported on the result, low bits only.
  function automatic logic [IDX_W-1:0] to_idx(input logic [AW-1:0] a);
    logic [AW+IDX_W-1:0] wide;
    wide = {{IDX_W{1'b0}}, a};
    return wide[IDX_W-1:0];
  endfunction

endpackage

FILE: src/tsoa_store.sv
// Word storage shared by both stacks: one write port, one read port.
// Read data is registered and holds while no read is issued. Uses tsoa_pkg.

module tsoa_store (
  input  logic                              clk_i,
  input  tsoa_pkg::mem_req_t                req_i,
  output logic signed [tsoa_pkg::DATA_W-1:0] rdata_o
);
  import tsoa_pkg::*;

  logic signed [DATA_W-1:0] mem_q [DEPTH];
  logic signed [DATA_W-1:0] rdata_q;

  // Synchronous write.
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
  end

  // Synchronous read; the last read word stays until the next read.
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/tsoa_ctrl.sv
// Sequencer for the two stacks: holds the stack counts, drives the storage
// ports and produces result beats. Uses tsoa_pkg.

module tsoa_ctrl (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Item input.
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [2:0]                         in_op_i,
  input  logic                               in_side_i,
  input  logic signed [tsoa_pkg::DATA_W-1:0] in_value_i,
  input  logic signed [tsoa_pkg::DATA_W-1:0] in_new_value_i,
  // Result output.
  output logic                               res_valid_o,
  input  logic                               res_ready_i,
  output tsoa_pkg::res_t                     res_o,
  // Storage port.
  output tsoa_pkg::mem_req_t                 mem_req_o,
  input  logic signed [tsoa_pkg::DATA_W-1:0] mem_rdata_i
);
  import tsoa_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_POPW,
    S_WALK,
    S_EMIT
  } state_e;

  state_e                   state_q;
  logic [2:0]               op_q;
  logic                     side_q;
  logic signed [DATA_W-1:0] val_q;
  logic signed [DATA_W-1:0] nval_q;
  logic [CNT_W-1:0]         low_q;
  logic [CNT_W-1:0]         high_q;
  logic [CNT_W-1:0]         n_q;
  logic                     rd_pend_q;
  logic [AW-1:0]            pidx_q;
  logic                     hold_vld_q;
  logic [AW-1:0]            hold_idx_q;
  logic signed [DATA_W-1:0] hold_val_q;
  res_t                     res_q;

  logic [CNT_W-1:0] cur_cnt;
  logic [CNT_W:0]   total;
  logic             full;
  logic             empty;
  logic [AW-1:0]    push_idx;
  logic [AW-1:0]    pop_idx;
  logic [AW-1:0]    walk_idx;
  logic             match;
  logic             emit_early;
  logic             consume;
  logic             more;
  logic             issue;
  logic             done;

  // Stack occupancy and the indexes that the current item touches.
  assign cur_cnt  = (side_q == SIDE_HIGH) ? high_q : low_q;
  assign total    = {1'b0, low_q} + {1'b0, high_q};
  assign full     = (total >= (CNT_W + 1)'(DEPTH));
  assign empty    = (cur_cnt == '0);
  assign push_idx = slot_of(side_q, cur_cnt);
  assign pop_idx  = slot_of(side_q, cur_cnt - CNT_W'(1));
  assign walk_idx = slot_of(side_q, n_q);

  // Walk control: one read in flight, one matched entry held back so that
  // the final beat of the run can carry last.
  assign match      = (op_q == OP_DUMP) || (mem_rdata_i == val_q);
  assign emit_early = (state_q == S_WALK) && rd_pend_q && match && hold_vld_q;
  assign consume    = (state_q == S_WALK) && rd_pend_q &&
                      (!(match && hold_vld_q) || res_ready_i);
  assign more       = (n_q != cur_cnt);
  assign issue      = (state_q == S_WALK) && more && (!rd_pend_q || consume);
  assign done       = (state_q == S_WALK) && !rd_pend_q && !more;

  assign in_ready_o = (state_q == S_IDLE);

  // Result beat selection.
  always_comb begin
    res_valid_o = 1'b0;
    res_o       = res_q;
    if (state_q == S_EMIT) begin
      res_valid_o = 1'b1;
    end else if (emit_early) begin
      res_valid_o  = 1'b1;
      res_o.status = ST_OK;
      res_o.index  = to_idx(hold_idx_q);
      res_o.value  = hold_val_q;
      res_o.last   = 1'b0;
    end else if (done) begin
      res_valid_o = 1'b1;
      res_o.last  = 1'b1;
      if (hold_vld_q) begin
        res_o.status = ST_OK;
        res_o.index  = to_idx(hold_idx_q);
        res_o.value  = hold_val_q;
      end else begin
        res_o.status = ST_NOTFOUND;
        res_o.index  = '0;
        res_o.value  = '0;
      end
    end
  end

  // Storage requests.
  always_comb begin
    mem_req_o = '0;
    if ((state_q == S_EXEC) && (op_q == OP_PUSH) && !full) begin
      mem_req_o.we    = 1'b1;
      mem_req_o.waddr = push_idx;
      mem_req_o.wdata = val_q;
    end else if (consume && match && (op_q == OP_REPLACE)) begin
      mem_req_o.we    = 1'b1;
      mem_req_o.waddr = pidx_q;
      mem_req_o.wdata = nval_q;
    end
    if ((state_q == S_EXEC) && (op_q == OP_POP) && !empty) begin
      mem_req_o.re    = 1'b1;
      mem_req_o.raddr = pop_idx;
    end else if (issue) begin
      mem_req_o.re    = 1'b1;
      mem_req_o.raddr = walk_idx;
    end
  end

  // State, counts and registered result fields.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      low_q      <= '0;
      high_q     <= '0;
      n_q        <= '0;
      rd_pend_q  <= 1'b0;
      hold_vld_q <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            op_q    <= in_op_i;
            side_q  <= in_side_i;
            val_q   <= in_value_i;
            nval_q  <= in_new_value_i;
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          res_q.status <= ST_OK;
          res_q.index  <= '0;
          res_q.value  <= '0;
          res_q.last   <= 1'b1;
          priority if (op_q > OP_DUMP) begin
            state_q <= S_EMIT;
          end else if (op_q == OP_PUSH) begin
            if (full) begin
              res_q.status <= ST_OVERFLOW;
            end else begin
              res_q.index <= to_idx(push_idx);
              if (side_q == SIDE_HIGH) begin
                high_q <= high_q + CNT_W'(1);
              end else begin
                low_q <= low_q + CNT_W'(1);
              end
            end
            state_q <= S_EMIT;
          end else if (empty) begin
            res_q.status <= ST_EMPTY;
            state_q      <= S_EMIT;
          end else if (op_q == OP_POP) begin
            res_q.index <= to_idx(pop_idx);
            if (side_q == SIDE_HIGH) begin
              high_q <= high_q - CNT_W'(1);
            end else begin
              low_q <= low_q - CNT_W'(1);
            end
            state_q <= S_POPW;
          end else begin
            n_q        <= '0;
            rd_pend_q  <= 1'b0;
            hold_vld_q <= 1'b0;
            state_q    <= S_WALK;
          end
        end
        S_POPW: begin
          res_q.value <= mem_rdata_i;
          state_q     <= S_EMIT;
        end
        S_WALK: begin
          if (issue) begin
            n_q       <= n_q + CNT_W'(1);
            pidx_q    <= walk_idx;
            rd_pend_q <= 1'b1;
          end else if (consume) begin
            rd_pend_q <= 1'b0;
          end
          if (consume && match) begin
            hold_vld_q <= 1'b1;
            hold_idx_q <= pidx_q;
            hold_val_q <= mem_rdata_i;
          end
          if (done && res_ready_i) begin
            state_q <= S_IDLE;
          end
        end
        S_EMIT: begin
          if (res_ready_i) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: src/two_stacks_one_array.sv
// Top level of the two-stacks-in-one-array block: stream ports and output register.
// Instantiates tsoa_ctrl and tsoa_store; uses tsoa_pkg.
//
//   channel   direction  tdata (low bit up)          tuser          tlast
//   s_axis    in         value, new_value (64 bits)  op, side       -
//   m_axis    out        index, value_res, 4'b0      status         last
//
// Push, unknown operations and failed items pass through the execute and emit states to the
// output register; pop adds a wait state for the registered storage read.
// Search, replace and dump walk a stack of n entries with one storage read per entry
// through the single read port.
// Reset clears both stack counts at once; the storage needs no clearing pass.
// A stalled result holds the walk; a new item is taken while the last beat waits.

module two_stacks_one_array (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // value [31:0], new_value [63:32]
  input  logic [3:0]  s_axis_tuser,   // op [2:0], side [3]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // index [3:0], value_res [35:4], zero [39:36]
  output logic [1:0]  m_axis_tuser,   // status [1:0]
  output logic        m_axis_tlast
);
  import tsoa_pkg::*;

  logic                     res_valid;
  logic                     res_ready;
  res_t                     res;
  mem_req_t                 mem_req;
  logic signed [DATA_W-1:0] mem_rdata;
  logic                     out_vld_q;
  res_t                     out_q;

  tsoa_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .in_op_i        (s_axis_tuser[2:0]),
    .in_side_i      (s_axis_tuser[3]),
    .in_value_i     (s_axis_tdata[31:0]),
    .in_new_value_i (s_axis_tdata[63:32]),
    .res_valid_o    (res_valid),
    .res_ready_i    (res_ready),
    .res_o          (res),
    .mem_req_o      (mem_req),
    .mem_rdata_i    (mem_rdata)
  );

  tsoa_store u_store (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  // Output register between the sequencer and the result stream.
  assign res_ready = !out_vld_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (res_ready) begin
      out_vld_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {4'b0000, out_q.value, out_q.index};
  assign m_axis_tuser  = out_q.status;
  assign m_axis_tlast  = out_q.last;

endmodule

FILE: verif/two_stacks_one_array_checker.sv
// Scoreboard for the two-stacks-in-one-array block: watches both stream channels,
// keeps its own copy of the shared array and the stack depths, and compares every beat.
// Depends on tsoa_pkg for sizes and operation, side and status codes.
`timescale 1ns / 100ps

module two_stacks_one_array_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // value [31:0], new_value [63:32]
  input  logic [3:0]  s_axis_tuser,   // op [2:0], side [3]
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [39:0] m_axis_tdata,   // index [3:0], value_res [35:4], zero [39:36]
  input  logic [1:0]  m_axis_tuser,   // status [1:0]
  input  logic        m_axis_tlast,
  output int          mismatches_o,
  output int          pending_o,
  output int          beats_seen_o
);
  import tsoa_pkg::*;

  // One result beat as the scoreboard expects it.
  typedef struct packed {
    logic [1:0]        status;
    logic [IDX_W-1:0]  index;
    logic [DATA_W-1:0] word;
    logic              last;
  } beat_t;

  beat_t             result_fifo[$];
  logic [DATA_W-1:0] shadow_array [DEPTH];
  int unsigned       low_depth;
  int unsigned       high_depth;
  int                fail_total;
  int                beat_total;

  initial begin
    low_depth  = 0;
    high_depth = 0;
    fail_total = 0;
    beat_total = 0;
  end

  // Array position of the n-th entry of a stack, counted from its bottom.
  function automatic int unsigned slot(input logic side, input int unsigned n);
    return (side == SIDE_HIGH) ? (DEPTH - 1 - n) : n;
  endfunction

  function automatic beat_t make_beat(input logic [1:0] status, input int unsigned pos,
                                      input logic [DATA_W-1:0] word, input logic last);
    beat_t b;
    b.status = status;
    b.index  = IDX_W'(pos);
    b.word   = word;
    b.last   = last;
    return b;
  endfunction

  task automatic report(input string msg);
    if (fail_total < 40) $display("ERROR at %0t ns: %s", $time, msg);
    fail_total++;
  endtask

  // Apply one accepted request to the shadow stacks and queue the beats it causes.
  task automatic stack_op(input logic [2:0] op, input logic side,
                          input logic [DATA_W-1:0] word, input logic [DATA_W-1:0] new_word);
    int unsigned fill;
    int unsigned pos;
    int unsigned n;
    beat_t       held;
    bit          have_held;
    fill      = (side == SIDE_HIGH) ? high_depth : low_depth;
    have_held = 1'b0;
    held      = '0;
    if (op > OP_DUMP) begin
      result_fifo.push_back(make_beat(ST_OK, 0, '0, 1'b1));
    end else if (op == OP_PUSH) begin
      if (low_depth + high_depth >= DEPTH) begin
        result_fifo.push_back(make_beat(ST_OVERFLOW, 0, '0, 1'b1));
      end else begin
        pos = slot(side, fill);
        shadow_array[pos] = word;
        if (side == SIDE_HIGH) high_depth++;
        else low_depth++;
        result_fifo.push_back(make_beat(ST_OK, pos, '0, 1'b1));
      end
    end else if (fill == 0) begin
      result_fifo.push_back(make_beat(ST_EMPTY, 0, '0, 1'b1));
    end else if (op == OP_POP) begin
      pos = slot(side, fill - 1);
      result_fifo.push_back(make_beat(ST_OK, pos, shadow_array[pos], 1'b1));
      if (side == SIDE_HIGH) high_depth--;
      else low_depth--;
    end else begin
      // Walk from the bottom of the stack; a beat is queued once the next one is known,
      // so that the final beat of the run can carry last.
      for (n = 0; n < fill; n++) begin
        pos = slot(side, n);
        if (op == OP_DUMP || shadow_array[pos] == word) begin
          if (have_held) result_fifo.push_back(held);
          held      = make_beat(ST_OK, pos, shadow_array[pos], 1'b0);
          have_held = 1'b1;
          if (op == OP_REPLACE) shadow_array[pos] = new_word;
        end
      end
      if (have_held) begin
        held.last = 1'b1;
        result_fifo.push_back(held);
      end else begin
        result_fifo.push_back(make_beat(ST_NOTFOUND, 0, '0, 1'b1));
      end
    end
  endtask

  // Result beats are checked before the request of the same edge is modeled, so a
  // stray beat can never be matched against expectations it did not cause.
  always @(posedge clk_i) begin
    beat_t want;
    beat_t got;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        beat_total++;
        got.status = m_axis_tuser;
        got.index  = m_axis_tdata[3:0];
        got.word   = m_axis_tdata[35:4];
        got.last   = m_axis_tlast;
        if (result_fifo.size() == 0) begin
          report($sformatf("unexpected beat status=%0d index=%0d value=%h last=%0b",
                           got.status, got.index, got.word, got.last));
        end else begin
          want = result_fifo.pop_front();
          if (got !== want || m_axis_tdata[39:36] !== 4'b0) begin
            report($sformatf({"beat mismatch: got status=%0d index=%0d value=%h last=%0b",
                              " pad=%h, want status=%0d index=%0d value=%h last=%0b"},
                             got.status, got.index, got.word, got.last, m_axis_tdata[39:36],
                             want.status, want.index, want.word, want.last));
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        stack_op(s_axis_tuser[2:0], s_axis_tuser[3], s_axis_tdata[31:0], s_axis_tdata[63:32]);
      end
    end
    mismatches_o <= fail_total;
    pending_o    <= result_fifo.size();
    beats_seen_o <= beat_total;
  end

endmodule

FILE: verif/two_stacks_one_array_test.sv
// Testbench top for the two-stacks-in-one-array block: clock, reset, request stimulus
// with random idling on both channels, and the final verdict.
// Depends on tsoa_pkg, two_stacks_one_array and two_stacks_one_array_checker.
`timescale 1ns / 100ps

module two_stacks_one_array_test;
  import tsoa_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;   // value [31:0], new_value [63:32]
  logic [3:0]  s_axis_tuser = '0;   // op [2:0], side [3]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;        // index [3:0], value_res [35:4], zero [39:36]
  logic [1:0]  m_axis_tuser;        // status [1:0]
  logic        m_axis_tlast;

  int mismatches;
  int pending;
  int beats_seen;
  int send_idle_pct = 8;
  int recv_idle_pct = 69;
  int requests_sent = 0;
  int cycle_count = 0;

  two_stacks_one_array dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  two_stacks_one_array_checker scoreboard (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .mismatches_o  (mismatches),
    .pending_o     (pending),
    .beats_seen_o  (beats_seen)
  );

  always #10 clk_i = ~clk_i;

  // Receiver backpressure, redrawn every cycle.
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Watchdog on the whole run.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Run stopped after %0d cycles with %0d beats outstanding.", cycle_count, pending);
    $display("** two_stacks_one_array: FAILED **");
    $finish;
  end

  // Offer one request beat, after a random idle gap, and hold it until accepted.
  task automatic send_request(input logic [2:0] op, input logic side,
                              input logic [31:0] word, input logic [31:0] new_word);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {new_word, word};
    s_axis_tuser  <= {side, op};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    requests_sent++;
  endtask

  // Stop sending until every queued result beat has come out.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Words are drawn mostly from a small pool so that searches and replaces hit often.
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 6))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h7FFF_FFFF;
      3: return 32'h8000_0000;
      4: return 32'($urandom_range(0, 3));
      default: return $urandom;
    endcase
  endfunction

  // Random traffic that swings between filling and draining the array.
  task automatic random_requests(input int count);
    int          k;
    int          r;
    bit          filling;
    logic [2:0]  op;
    filling = 1'b1;
    for (k = 0; k < count; k++) begin
      if (k % 24 == 0) filling = ~filling;
      r = $urandom_range(0, 99);
      if (r < 3) op = 3'($urandom_range(5, 7));
      else if (r < (filling ? 58 : 20)) op = OP_PUSH;
      else if (r < (filling ? 68 : 58)) op = OP_POP;
      else if (r < 79) op = OP_SEARCH;
      else if (r < 90) op = OP_REPLACE;
      else op = OP_DUMP;
      send_request(op, 1'($urandom_range(0, 1)), pick_word(), pick_word());
    end
  endtask

  initial begin
    int k;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: every operation on empty stacks, extreme words, unknown code,
    // search hit and miss, replace, dumps, then fill the array until a push overflows.
    send_request(OP_POP,     SIDE_LOW,  32'h0, 32'h0);
    send_request(OP_SEARCH,  SIDE_HIGH, 32'h0, 32'h0);
    send_request(OP_REPLACE, SIDE_LOW,  32'h0, 32'h1);
    send_request(OP_DUMP,    SIDE_HIGH, 32'h0, 32'h0);
    send_request(OP_PUSH,    SIDE_LOW,  32'h8000_0000, 32'hFFFF_FFFF);
    send_request(OP_PUSH,    SIDE_LOW,  32'h7FFF_FFFF, 32'h0);
    send_request(OP_PUSH,    SIDE_HIGH, 32'h0000_0000, 32'h8000_0000);
    send_request(OP_PUSH,    SIDE_HIGH, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
    send_request(OP_SEARCH,  SIDE_LOW,  32'h7FFF_FFFF, 32'h0);
    send_request(OP_SEARCH,  SIDE_HIGH, 32'h0000_0005, 32'h0);
    send_request(OP_REPLACE, SIDE_HIGH, 32'hFFFF_FFFF, 32'h8000_0000);
    send_request(OP_DUMP,    SIDE_HIGH, 32'h0, 32'h0);
    send_request(3'b111,     SIDE_HIGH, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    for (k = 0; k < 12; k++) begin
      send_request(OP_PUSH, 1'(k % 2), 32'(k % 3), $urandom);
    end
    send_request(OP_PUSH,    SIDE_LOW,  32'h1234_5678, 32'h0);
    send_request(OP_DUMP,    SIDE_LOW,  32'h0, 32'h0);
    drain_results();

    // Random traffic in three idling phases, with a full drain between phases.
    random_requests(100);
    drain_results();
    send_idle_pct <= 69;
    recv_idle_pct <= 8;
    random_requests(100);
    drain_results();
    send_idle_pct <= 0;
    recv_idle_pct <= 0;
    random_requests(100);
    drain_results();
    repeat (30) @(posedge clk_i);

    $display("Covered %0d requests (push, pop, search, replace, dump, unknown codes) on both",
             requests_sent);
    $display("stacks through empty and full array states; %0d result beats compared.",
             beats_seen);
    if (mismatches == 0 && pending == 0) begin
      $display("** two_stacks_one_array: PASSED **");
    end else begin
      $display("** two_stacks_one_array: FAILED **");
    end
    $finish;
  end

endmodule
